>>> sv/lisp_token_splitter_core_assert.svh
// Assertion macros shared by the tokenizer modules.
`ifndef LISP_TOKEN_SPLITTER_CORE_ASSERT_SVH
`define LISP_TOKEN_SPLITTER_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define LTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define LTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/lts_pkg.sv
// Types, character codes and classifiers for the Lisp tokenizer.
`timescale 1ns / 1ps
package lts_pkg;

    localparam logic [2:0] KIND_SPECIAL = 3'd0;
    localparam logic [2:0] KIND_STRING  = 3'd1;
    localparam logic [2:0] KIND_COMMENT = 3'd2;
    localparam logic [2:0] KIND_NUMBER  = 3'd3;
    localparam logic [2:0] KIND_SYMBOL  = 3'd4;

    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_LBRC   = 8'h7B;
    localparam logic [7:0] CH_RBRC   = 8'h7D;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BQUOTE = 8'h60;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_TILDE,
        MODE_STR,
        MODE_STR_ESC,
        MODE_COMMENT,
        MODE_MINUS,
        MODE_NUM,
        MODE_SYM
    } t_mode;

    typedef struct packed {
        logic [7:0] ch;
        logic [2:0] kind;
        logic       first;
        logic       last;
        logic       unterm;
        logic       run_last;
    } t_res;

    // One queue entry: all results of one input word, first in slot a.
    typedef struct packed {
        t_res a;
        t_res b;
        logic has_b;
    } t_pair;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) || (c == CH_COMMA);
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        return is_blank(c) || (c == CH_LBRK) || (c == CH_RBRK) || (c == CH_LBRC)
            || (c == CH_RBRC) || (c == CH_LPAR) || (c == CH_RPAR) || (c == CH_SQUOTE)
            || (c == CH_DQUOTE) || (c == CH_BQUOTE) || (c == CH_SEMI);
    endfunction

    function automatic logic is_single(input logic [7:0] c);
        return (c == CH_LBRK) || (c == CH_RBRK) || (c == CH_LBRC) || (c == CH_RBRC)
            || (c == CH_LPAR) || (c == CH_RPAR) || (c == CH_SQUOTE) || (c == CH_BQUOTE)
            || (c == CH_CARET) || (c == CH_AT);
    endfunction

endpackage

>>> sv/lisp_token_splitter_core.sv
// Top level of the streaming Lisp tokenizer.
//   channel  direction  handshake         payload
//   input    in         i_valid/o_stall   i_char_in, i_is_final
//   output   out        o_valid/i_stall   o_char_out, o_token_kind, o_token_first,
//                                         o_token_last, o_unterminated, o_run_last
// One character is accepted per cycle while o_stall is low; a word with two results
// (final character) yields two output words, all others zero or one.
// After acceptance a result is written into the queue by the front logic, then moved
// from the queue into the output register.
// A four-entry queue lets the input keep flowing while i_stall holds the output.
// Synchronous active-low reset returns the lexer to idle with nothing held.
`timescale 1ns / 1ps
module lisp_token_splitter_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_in,
    input  logic       i_is_final,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_char_out,
    output logic [2:0] o_token_kind,
    output logic       o_token_first,
    output logic       o_token_last,
    output logic       o_unterminated,
    output logic       o_run_last
);

    lts_pkg::t_q_status q_status;
    lts_pkg::t_pair     push_entry;
    lts_pkg::t_pair     head_entry;
    lts_pkg::t_res      res;
    logic               accept;
    logic               push;
    logic               pop;

    assign o_stall = q_status.full;

    lts_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_char_in  (i_char_in),
        .i_is_final (i_is_final),
        .i_q_status (q_status),
        .o_accept   (accept),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    lts_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push && accept),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_entry  (head_entry),
        .o_status (q_status)
    );

    lts_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_entry    (head_entry),
        .i_q_status (q_status),
        .i_stall    (i_stall),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .o_res      (res)
    );

    assign o_char_out     = res.ch;
    assign o_token_kind   = res.kind;
    assign o_token_first  = res.first;
    assign o_token_last   = res.last;
    assign o_unterminated = res.unterm;
    assign o_run_last     = res.run_last;

endmodule

>>> sv/lts_front.sv
// Front end: lexer state, one-character hold and result building per input word.
`timescale 1ns / 1ps
`include "lisp_token_splitter_core_assert.svh"
module lts_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_char_in,
    input  logic              i_is_final,
    input  lts_pkg::t_q_status i_q_status,
    output logic              o_accept,
    output logic              o_push,
    output lts_pkg::t_pair    o_entry
);

    lts_pkg::t_mode r_mode, n_mode;
    logic [7:0]     r_held_char, n_held_char;
    logic           r_held_valid, n_held_valid;
    logic [2:0]     r_held_kind, n_held_kind;
    logic           r_held_first, n_held_first;

    logic           cont;
    logic [2:0]     cont_kind;
    lts_pkg::t_mode cont_mode;
    logic [2:0]     eff_kind;
    logic           new_valid;
    logic [2:0]     new_kind;
    logic           new_first;
    lts_pkg::t_mode new_mode;
    lts_pkg::t_res  res_a, res_b;
    logic           b_valid;

    assign o_accept = i_valid && !i_q_status.full;

    // Classify the incoming character against the current mode.
    always_comb begin
        cont      = 1'b0;
        cont_kind = lts_pkg::KIND_SPECIAL;
        cont_mode = lts_pkg::MODE_IDLE;
        eff_kind  = r_held_kind;
        unique case (r_mode)
            lts_pkg::MODE_IDLE: begin
                cont = 1'b0;
            end
            lts_pkg::MODE_TILDE: begin
                cont = (i_char_in == lts_pkg::CH_AT);
            end
            lts_pkg::MODE_STR: begin
                cont      = 1'b1;
                cont_kind = lts_pkg::KIND_STRING;
                if (i_char_in == lts_pkg::CH_DQUOTE) begin
                    cont_mode = lts_pkg::MODE_IDLE;
                end else if (i_char_in == lts_pkg::CH_BSLASH) begin
                    cont_mode = lts_pkg::MODE_STR_ESC;
                end else begin
                    cont_mode = lts_pkg::MODE_STR;
                end
            end
            lts_pkg::MODE_STR_ESC: begin
                cont      = 1'b1;
                cont_kind = lts_pkg::KIND_STRING;
                cont_mode = lts_pkg::MODE_STR;
            end
            lts_pkg::MODE_COMMENT: begin
                cont      = (i_char_in != lts_pkg::CH_NL);
                cont_kind = lts_pkg::KIND_COMMENT;
                cont_mode = lts_pkg::MODE_COMMENT;
            end
            lts_pkg::MODE_MINUS: begin
                if (lts_pkg::is_digit(i_char_in)) begin
                    eff_kind  = lts_pkg::KIND_NUMBER;
                    cont      = 1'b1;
                    cont_kind = lts_pkg::KIND_NUMBER;
                    cont_mode = lts_pkg::MODE_NUM;
                end else begin
                    // Lone minus: it turns into a symbol.
                    eff_kind  = lts_pkg::KIND_SYMBOL;
                    cont      = !lts_pkg::is_delim(i_char_in);
                    cont_kind = lts_pkg::KIND_SYMBOL;
                    cont_mode = lts_pkg::MODE_SYM;
                end
            end
            lts_pkg::MODE_NUM: begin
                cont      = lts_pkg::is_digit(i_char_in);
                cont_kind = lts_pkg::KIND_NUMBER;
                cont_mode = lts_pkg::MODE_NUM;
            end
            lts_pkg::MODE_SYM: begin
                cont      = !lts_pkg::is_delim(i_char_in);
                cont_kind = lts_pkg::KIND_SYMBOL;
                cont_mode = lts_pkg::MODE_SYM;
            end
        endcase
    end

    // Decide what the incoming character becomes when it is held.
    always_comb begin
        new_valid = 1'b1;
        new_first = 1'b1;
        new_kind  = lts_pkg::KIND_SYMBOL;
        new_mode  = lts_pkg::MODE_SYM;
        priority if (cont) begin
            new_first = 1'b0;
            new_kind  = cont_kind;
            new_mode  = cont_mode;
        end else if (lts_pkg::is_blank(i_char_in)) begin
            new_valid = 1'b0;
            new_mode  = lts_pkg::MODE_IDLE;
        end else if (i_char_in == lts_pkg::CH_TILDE) begin
            new_kind = lts_pkg::KIND_SPECIAL;
            new_mode = lts_pkg::MODE_TILDE;
        end else if (lts_pkg::is_single(i_char_in)) begin
            new_kind = lts_pkg::KIND_SPECIAL;
            new_mode = lts_pkg::MODE_IDLE;
        end else if (i_char_in == lts_pkg::CH_DQUOTE) begin
            new_kind = lts_pkg::KIND_STRING;
            new_mode = lts_pkg::MODE_STR;
        end else if (i_char_in == lts_pkg::CH_SEMI) begin
            new_kind = lts_pkg::KIND_COMMENT;
            new_mode = lts_pkg::MODE_COMMENT;
        end else if (i_char_in == lts_pkg::CH_MINUS) begin
            new_kind = lts_pkg::KIND_NUMBER;
            new_mode = lts_pkg::MODE_MINUS;
        end else if ((i_char_in >= lts_pkg::CH_ONE) && (i_char_in <= lts_pkg::CH_NINE)) begin
            new_kind = lts_pkg::KIND_NUMBER;
            new_mode = lts_pkg::MODE_NUM;
        end else begin
            new_kind = lts_pkg::KIND_SYMBOL;
            new_mode = lts_pkg::MODE_SYM;
        end
    end

    // Next state: load the hold, or clear everything after the final word.
    always_comb begin
        n_mode       = r_mode;
        n_held_char  = r_held_char;
        n_held_valid = r_held_valid;
        n_held_kind  = r_held_kind;
        n_held_first = r_held_first;
        if (o_accept) begin
            if (i_is_final) begin
                n_mode       = lts_pkg::MODE_IDLE;
                n_held_char  = '0;
                n_held_valid = 1'b0;
                n_held_kind  = lts_pkg::KIND_SPECIAL;
                n_held_first = 1'b0;
            end else begin
                n_mode       = new_mode;
                n_held_valid = new_valid;
                if (new_valid) begin
                    n_held_char  = i_char_in;
                    n_held_kind  = new_kind;
                    n_held_first = new_first;
                end
            end
        end
    end

    // Outputs: the released held character, then on the final word the flushed one.
    always_comb begin
        b_valid        = i_is_final && new_valid;

        res_a.ch       = r_held_char;
        res_a.kind     = eff_kind;
        res_a.first    = r_held_first;
        res_a.last     = !cont;
        res_a.unterm   = 1'b0;
        res_a.run_last = !b_valid;

        res_b.ch       = i_char_in;
        res_b.kind     = (new_mode == lts_pkg::MODE_MINUS) ? lts_pkg::KIND_SYMBOL : new_kind;
        res_b.first    = new_first;
        res_b.last     = 1'b1;
        res_b.unterm   = (new_mode == lts_pkg::MODE_STR) || (new_mode == lts_pkg::MODE_STR_ESC);
        res_b.run_last = 1'b1;

        o_push = o_accept && (r_held_valid || b_valid);
        if (r_held_valid) begin
            o_entry.a     = res_a;
            o_entry.b     = res_b;
            o_entry.has_b = b_valid;
        end else begin
            o_entry.a     = res_b;
            o_entry.b     = res_b;
            o_entry.has_b = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= lts_pkg::MODE_IDLE;
            r_held_char  <= '0;
            r_held_valid <= 1'b0;
            r_held_kind  <= lts_pkg::KIND_SPECIAL;
            r_held_first <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_held_char  <= n_held_char;
            r_held_valid <= n_held_valid;
            r_held_kind  <= n_held_kind;
            r_held_first <= n_held_first;
        end
    end

    `LTS_ASSERT_NOW(a_mode_has_hold, i_clk, i_rst_n, r_mode != lts_pkg::MODE_IDLE, r_held_valid, "token mode without a held character")
    `LTS_ASSERT_NEXT(a_final_clears, i_clk, i_rst_n, o_accept && i_is_final, !r_held_valid && (r_mode == lts_pkg::MODE_IDLE), "final word left state behind")
    `LTS_ASSERT_NOW(a_minus_hold, i_clk, i_rst_n, r_mode == lts_pkg::MODE_MINUS, r_held_first && (r_held_kind == lts_pkg::KIND_NUMBER) && (r_held_char == lts_pkg::CH_MINUS), "minus mode holds a wrong character")

endmodule

>>> sv/lts_queue.sv
// Short queue of per-word result pairs between front and back.
`timescale 1ns / 1ps
`include "lisp_token_splitter_core_assert.svh"
module lts_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  lts_pkg::t_pair     i_entry,
    input  logic               i_pop,
    output lts_pkg::t_pair     o_entry,
    output lts_pkg::t_q_status o_status
);

    lts_pkg::t_pair            r_mem [lts_pkg::QDEPTH];
    logic [lts_pkg::QAW-1:0]   r_wr, n_wr;
    logic [lts_pkg::QAW-1:0]   r_rd, n_rd;
    logic [lts_pkg::QAW:0]     r_count, n_count;

    assign o_status.full  = (r_count == (lts_pkg::QAW+1)'(lts_pkg::QDEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_entry        = r_mem[r_rd];

    always_comb begin
        n_wr    = i_push ? r_wr + 1'b1 : r_wr;
        n_rd    = i_pop ? r_rd + 1'b1 : r_rd;
        n_count = r_count + (lts_pkg::QAW+1)'(i_push) - (lts_pkg::QAW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    `LTS_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, i_push, !o_status.full, "push into a full queue")

endmodule

>>> sv/lts_back.sv
// Back end: unpacks queue entries into single output words behind a register.
`timescale 1ns / 1ps
`include "lisp_token_splitter_core_assert.svh"
module lts_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lts_pkg::t_pair     i_entry,
    input  lts_pkg::t_q_status i_q_status,
    input  logic               i_stall,
    output logic               o_pop,
    output logic               o_valid,
    output lts_pkg::t_res      o_res
);

    logic          r_out_valid, n_out_valid;
    lts_pkg::t_res r_out, n_out;
    logic          r_pend_valid, n_pend_valid;
    lts_pkg::t_res r_pend, n_pend;
    logic          out_free;

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = out_free && !r_pend_valid && !i_q_status.empty;
    assign o_valid  = r_out_valid;
    assign o_res    = r_out;

    // Advance: pending second word first, then the next queue entry.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        if (out_free) begin
            if (r_pend_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_pend;
                n_pend_valid = 1'b0;
            end else if (o_pop) begin
                n_out_valid  = 1'b1;
                n_out        = i_entry.a;
                n_pend_valid = i_entry.has_b;
                n_pend       = i_entry.b;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_pend <= n_pend;
    end

    `LTS_ASSERT_NOW(a_pend_behind_out, i_clk, i_rst_n, r_pend_valid, r_out_valid && !r_out.run_last, "pending word without an open run")

endmodule

>>> dv/tb_lisp_token_splitter_core.sv
// Self-checking testbench for the streaming Lisp tokenizer core.
`timescale 1ns / 1ps
module tb_lisp_token_splitter_core;
    import lts_pkg::*;

    localparam int WORD_TARGET = 1050;
    localparam int QUIET_LIMIT = 1000;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } src_word_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_char_in = 8'h00;
    logic       i_is_final = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_char_out;
    logic [2:0] o_token_kind;
    logic       o_token_first;
    logic       o_token_last;
    logic       o_unterminated;
    logic       o_run_last;

    lisp_token_splitter_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_char_in      (i_char_in),
        .i_is_final     (i_is_final),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_char_out     (o_char_out),
        .o_token_kind   (o_token_kind),
        .o_token_first  (o_token_first),
        .o_token_last   (o_token_last),
        .o_unterminated (o_unterminated),
        .o_run_last     (o_run_last)
    );

    always #5 i_clk = ~i_clk;

    src_word_t  source_chars[$];
    t_res       token_bytes_due[$];
    int         source_total;
    int         words_taken = 0;
    int         mismatches = 0;
    int         gap_left = 0;
    int         stall_left = 0;
    int         src_steady = 0;
    int         sink_steady = 0;
    int         quiet_cycles = 0;
    src_word_t  next_word;

    // Lexer state of the predictor
    t_mode      lex_mode = MODE_IDLE;
    logic [7:0] held_byte = 8'h00;
    logic       held_live = 1'b0;
    logic [2:0] held_kind = KIND_SPECIAL;
    logic       held_first = 1'b0;

    function automatic logic digit_char(input logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic logic blank_char(input logic [7:0] c);
        case (c)
            CH_SPACE, CH_TAB, CH_NL, CH_COMMA: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic breaks_symbol(input logic [7:0] c);
        case (c)
            CH_SPACE, CH_TAB, CH_NL, CH_COMMA, CH_LBRK, CH_RBRK, CH_LBRC, CH_RBRC,
            CH_LPAR, CH_RPAR, CH_SQUOTE, CH_DQUOTE, CH_BQUOTE, CH_SEMI: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic lone_special(input logic [7:0] c);
        case (c)
            CH_LBRK, CH_RBRK, CH_LBRC, CH_RBRC, CH_LPAR, CH_RPAR, CH_SQUOTE, CH_BQUOTE,
            CH_CARET, CH_AT: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void take(input logic [7:0] c, input logic [2:0] kind,
                                 input logic first, input t_mode mode);
        held_byte = c;
        held_kind = kind;
        held_first = first;
        held_live = 1'b1;
        lex_mode = mode;
    endfunction

    // Advance the lexer by one accepted word and queue the bytes it releases.
    function automatic void lex_char(input logic [7:0] c, input logic fin);
        logic       joins;
        logic [2:0] next_kind;
        t_mode      next_mode;
        t_res       outq[$];
        joins = 1'b0;
        next_kind = KIND_SPECIAL;
        next_mode = MODE_IDLE;
        case (lex_mode)
            MODE_TILDE: begin
                if (c == CH_AT) begin
                    joins = 1'b1;
                    next_kind = KIND_SPECIAL;
                end
            end
            MODE_STR: begin
                joins = 1'b1;
                next_kind = KIND_STRING;
                if (c == CH_DQUOTE) next_mode = MODE_IDLE;
                else if (c == CH_BSLASH) next_mode = MODE_STR_ESC;
                else next_mode = MODE_STR;
            end
            MODE_STR_ESC: begin
                joins = 1'b1;
                next_kind = KIND_STRING;
                next_mode = MODE_STR;
            end
            MODE_COMMENT: begin
                if (c != CH_NL) begin
                    joins = 1'b1;
                    next_kind = KIND_COMMENT;
                    next_mode = MODE_COMMENT;
                end
            end
            MODE_MINUS: begin
                // the held minus becomes a number or a symbol now
                if (digit_char(c)) begin
                    held_kind = KIND_NUMBER;
                    joins = 1'b1;
                    next_kind = KIND_NUMBER;
                    next_mode = MODE_NUM;
                end else begin
                    held_kind = KIND_SYMBOL;
                    if (!breaks_symbol(c)) begin
                        joins = 1'b1;
                        next_kind = KIND_SYMBOL;
                        next_mode = MODE_SYM;
                    end
                end
            end
            MODE_NUM: begin
                if (digit_char(c)) begin
                    joins = 1'b1;
                    next_kind = KIND_NUMBER;
                    next_mode = MODE_NUM;
                end
            end
            MODE_SYM: begin
                if (!breaks_symbol(c)) begin
                    joins = 1'b1;
                    next_kind = KIND_SYMBOL;
                    next_mode = MODE_SYM;
                end
            end
            default: ;
        endcase

        if (held_live) outq.push_back('{held_byte, held_kind, held_first, !joins, 1'b0, 1'b0});
        held_live = 1'b0;

        if (joins) take(c, next_kind, 1'b0, next_mode);
        else if (blank_char(c)) lex_mode = MODE_IDLE;
        else if (c == CH_TILDE) take(c, KIND_SPECIAL, 1'b1, MODE_TILDE);
        else if (lone_special(c)) take(c, KIND_SPECIAL, 1'b1, MODE_IDLE);
        else if (c == CH_DQUOTE) take(c, KIND_STRING, 1'b1, MODE_STR);
        else if (c == CH_SEMI) take(c, KIND_COMMENT, 1'b1, MODE_COMMENT);
        else if (c == CH_MINUS) take(c, KIND_NUMBER, 1'b1, MODE_MINUS);
        else if (c inside {[CH_ONE:CH_NINE]}) take(c, KIND_NUMBER, 1'b1, MODE_NUM);
        else take(c, KIND_SYMBOL, 1'b1, MODE_SYM);

        if (fin) begin
            // flush the held byte and return to idle
            if (held_live)
                outq.push_back('{held_byte,
                                 (lex_mode == MODE_MINUS) ? KIND_SYMBOL : held_kind,
                                 held_first, 1'b1,
                                 lex_mode inside {MODE_STR, MODE_STR_ESC}, 1'b0});
            lex_mode = MODE_IDLE;
            held_byte = 8'h00;
            held_live = 1'b0;
            held_kind = KIND_SPECIAL;
            held_first = 1'b0;
        end

        if (outq.size() > 0) outq[outq.size() - 1].run_last = 1'b1;
        foreach (outq[k]) token_bytes_due.push_back(outq[k]);
    endfunction

    // Idle cycles before the next word; some stretches run with no idling at all.
    function automatic int draw_wait(inout int steady);
        if (steady > 0) begin
            steady--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            steady = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 5);
    endfunction

    task automatic note_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 200)
            $display("%0t: %s mismatch: got %0d, want %0d", $realtime, what, got, want);
    endtask

    task automatic next_due_check(input t_res want);
        if (o_char_out !== want.ch) note_mismatch("char_out", o_char_out, want.ch);
        if (o_token_kind !== want.kind) note_mismatch("token_kind", o_token_kind, want.kind);
        if (o_token_first !== want.first) note_mismatch("token_first", o_token_first, want.first);
        if (o_token_last !== want.last) note_mismatch("token_last", o_token_last, want.last);
        if (o_unterminated !== want.unterm)
            note_mismatch("unterminated", o_unterminated, want.unterm);
        if (o_run_last !== want.run_last) note_mismatch("run_last", o_run_last, want.run_last);
    endtask

    task automatic put(input logic [7:0] c);
        source_chars.push_back('{c, 1'b0});
    endtask

    task automatic put_text(input string s);
        for (int k = 0; k < s.len(); k++) put(s[k]);
    endtask

    task automatic end_text();
        source_chars[source_chars.size() - 1].fin = 1'b1;
    endtask

    task automatic add_random_token();
        string      sym_pool;
        string      gap_pool;
        string      spec_pool;
        int         len;
        logic [7:0] c;
        sym_pool = "abcxyz+*!?<>=/_~@^0123456789";
        gap_pool = " \t\n,";
        spec_pool = "[]{}()'`^@";
        case ($urandom_range(0, 11))
            0, 1: begin
                put(sym_pool[$urandom_range(0, 5)]);
                len = $urandom_range(0, 5);
                for (int k = 0; k < len; k++) put(sym_pool[$urandom_range(0, sym_pool.len() - 1)]);
            end
            2, 3: begin
                if ($urandom_range(0, 2) == 0) put(CH_MINUS);
                put(8'($urandom_range(CH_ONE, CH_NINE)));
                len = $urandom_range(0, 4);
                for (int k = 0; k < len; k++) put(8'($urandom_range(CH_ZERO, CH_NINE)));
            end
            4: begin
                put(CH_MINUS);
                if ($urandom_range(0, 1)) put(sym_pool[$urandom_range(0, sym_pool.len() - 1)]);
            end
            5: begin
                put(CH_DQUOTE);
                len = $urandom_range(0, 6);
                for (int k = 0; k < len; k++) begin
                    case ($urandom_range(0, 3))
                        0: begin
                            put(CH_BSLASH);
                            put(8'($urandom_range(0, 255)));
                        end
                        1: put(8'($urandom_range(0, 255)));
                        default: put(sym_pool[$urandom_range(0, sym_pool.len() - 1)]);
                    endcase
                end
                if ($urandom_range(0, 7) != 0) put(CH_DQUOTE);
            end
            6: begin
                put(CH_SEMI);
                len = $urandom_range(0, 8);
                for (int k = 0; k < len; k++) begin
                    c = 8'($urandom_range(0, 255));
                    put((c == CH_NL) ? CH_SPACE : c);
                end
                if ($urandom_range(0, 3) != 0) put(CH_NL);
            end
            7: put(spec_pool[$urandom_range(0, spec_pool.len() - 1)]);
            8: begin
                put(CH_TILDE);
                if ($urandom_range(0, 1)) put(CH_AT);
            end
            9: begin
                put(CH_ZERO);
                len = $urandom_range(0, 3);
                for (int k = 0; k < len; k++) put(8'($urandom_range(CH_ZERO, CH_NINE)));
            end
            10: put(8'($urandom_range(0, 255)));
            default: put(gap_pool[$urandom_range(0, gap_pool.len() - 1)]);
        endcase
        // separate the next token, or run straight into it
        case ($urandom_range(0, 3))
            0, 1: put(CH_SPACE);
            2: ;
            default: put(gap_pool[$urandom_range(0, gap_pool.len() - 1)]);
        endcase
        if ($urandom_range(0, 19) == 0) end_text();
    endtask

    // Driver: present pending words, predict each one as it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                lex_char(i_char_in, i_is_final);
                words_taken++;
                gap_left = draw_wait(src_steady);
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (source_chars.size() > 0) begin
                    next_word = source_chars.pop_front();
                    i_valid <= 1'b1;
                    i_char_in <= next_word.ch;
                    i_is_final <= next_word.fin;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result word against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (token_bytes_due.size() == 0) begin
                    note_mismatch("unexpected result, char", o_char_out, 0);
                end else begin
                    next_due_check(token_bytes_due.pop_front());
                end
                stall_left = draw_wait(sink_steady);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog: end the run when neither side moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("tb_lisp_token_splitter_core: errors");
                    $finish;
                end
            end
        end
    end

    initial begin
        // tilde-at merge, lone tilde
        put_text("~@~(");
        // text ends just after an escaped quote inside a string
        put_text("\"a\\\"");
        end_text();
        // minus with digit, minus starting a symbol, leading zero
        put_text("-7 -x 0");
        put_text(";c\n");
        put(8'h00);
        put(8'hFF);
        // number ended by a minus, then a lone minus at end of text
        put_text("12-");
        end_text();
        // text ends right after a backslash
        put_text("\"\\");
        end_text();

        while (source_chars.size() < WORD_TARGET) add_random_token();
        end_text();
        source_total = source_chars.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_taken < source_total) @(posedge i_clk);
        while (token_bytes_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("tb_lisp_token_splitter_core: clean");
        end else begin
            $display("tb_lisp_token_splitter_core: errors");
        end
        $finish;
    end

endmodule
